@@ hdl/tscc_pkg.sv @@
// Package for the scratchpad check/convert unit.
// Shared constants, the CRC-8 byte function and the frame result struct.
// No dependencies.
package tscc_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned TEMP_W = 14;
  localparam int unsigned FAIL_W = 3;
  localparam int unsigned WORD_W = 16;

  localparam logic [DATA_W-1:0] CRC_POLY      = 8'h8c;
  localparam logic [TEMP_W-1:0] TEMP_LIMIT    = 14'd10000;
  localparam logic [TEMP_W-1:0] TEMP_FALLBACK = 14'd2500;
  localparam logic [FAIL_W-1:0] RETRY_RESET   = 3'd5;

  // register index on the config port (paddr[3:2])
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;

  typedef struct packed {
    logic              last;    // frame closed by this byte
    logic              crc_ok;
    logic              retry;
    logic [WORD_W-1:0] word;    // {temp_high, temp_low}
  } frame_res_t;

  // reflected CRC-8, low bit first
  function automatic logic [DATA_W-1:0] crc8_byte(input logic [DATA_W-1:0] crc,
                                                  input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/tscc_frame.sv @@
// Frame tracker: byte position, running CRC, temperature bytes, retry count.
// Depends on tscc_pkg.
module tscc_frame
  import tscc_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              start_i,
  input  logic [FAIL_W-1:0] retry_limit_i,
  output frame_res_t        res_o
);

  localparam int unsigned POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]  pos_q, pos_d, pos_eff;
  logic [DATA_W-1:0] crc_q, crc_d, crc_eff;
  logic [DATA_W-1:0] lo_q, hi_q;
  logic [FAIL_W-1:0] fail_q, fail_d, fail_inc;
  logic              is_last, match;

  assign pos_eff  = start_i ? '0 : pos_q;
  assign crc_eff  = start_i ? '0 : crc_q;
  assign is_last  = (pos_eff == POS_LAST);
  assign match    = (data_i == crc_eff);
  assign fail_inc = fail_q + FAIL_W'(1);

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    fail_d = fail_q;
    if (is_last) begin
      pos_d = '0;
      crc_d = '0;
      if (match || (fail_inc >= retry_limit_i)) begin
        fail_d = '0;
      end else begin
        fail_d = fail_inc;
      end
    end else begin
      pos_d = pos_eff + POS_W'(1);
      crc_d = crc8_byte(crc_eff, data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= '0;
      fail_q <= '0;
    end else if (en_i) begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      fail_q <= fail_d;
    end
  end

  // temperature bytes: undefined until written
  always_ff @(posedge clk_i) begin
    if (en_i && !is_last && (pos_eff == POS_W'(0))) begin
      lo_q <= data_i;
    end
    if (en_i && !is_last && (pos_eff == POS_W'(1))) begin
      hi_q <= data_i;
    end
  end

  assign res_o.last   = is_last;
  assign res_o.crc_ok = match;
  assign res_o.retry  = !match && (fail_inc < retry_limit_i);
  assign res_o.word   = {hi_q, lo_q};

endmodule

@@ hdl/tscc_conv.sv @@
// Temperature conversion: (word & 0x87FF) * 625 / 100; 2500 if bit 15 is set or the result is 10000 or more.
// Depends on tscc_pkg.
module tscc_conv
  import tscc_pkg::*;
(
  input  logic [WORD_W-1:0] word_i,
  output logic [TEMP_W-1:0] temp_o
);

  // 625/100 = 25/4; with bit 15 clear the mask leaves bits 10:0
  logic [WORD_W-1:0] prod;
  logic [TEMP_W-1:0] val;

  assign prod = WORD_W'(word_i[10:0]) * WORD_W'(25);
  assign val  = prod[WORD_W-1:2];

  always_comb begin
    if (word_i[WORD_W-1] || (val >= TEMP_LIMIT)) begin
      temp_o = TEMP_FALLBACK;  // negative or out of range
    end else begin
      temp_o = val;
    end
  end

endmodule

@@ hdl/temperature_scratchpad_check_convert_unit.sv @@
// Scratchpad check/convert: takes one sensor scratchpad byte per transfer, checks the
// CRC-8 over the frame and gives one result per frame on its last byte (temperature in
// hundredths of a degree, CRC flag, retry request). A byte is accepted every cycle unless
// the input side stalls, which it does only while a finished result waits on the output
// side. The last byte passes the input register and then the result register.
// Depends on tscc_pkg, tscc_frame, tscc_conv.
module temperature_scratchpad_check_convert_unit
  import tscc_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [13:0] temperature_centi, [15:14] zero
  output logic [1:0]  m_axis_tuser,   // [0] crc_ok, [1] retry_needed
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              in_valid_q, in_valid_d;
  logic [DATA_W-1:0] data_q;
  logic              start_q;
  logic              s_xfer, advance;
  logic              out_valid_q, out_valid_d;
  logic [TEMP_W-1:0] temp_q, temp_conv;
  logic              ok_q, retry_q;
  logic [FAIL_W-1:0] retry_limit_q;
  frame_res_t        res;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[3:2] == REG_RETRY_LIMIT) ? {29'd0, retry_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RETRY_RESET;
    end else if (psel && penable && pwrite && (paddr[3:2] == REG_RETRY_LIMIT)) begin
      retry_limit_q <= pwdata[FAIL_W-1:0];
    end
  end

  // input register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      data_q  <= s_axis_tdata;
      start_q <= s_axis_tuser;
    end
  end

  tscc_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .data_i       (data_q),
    .start_i      (start_q),
    .retry_limit_i(retry_limit_q),
    .res_o        (res)
  );

  tscc_conv u_conv (
    .word_i(res.word),
    .temp_o(temp_conv)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res.last) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.last) begin
      temp_q  <= res.crc_ok ? temp_conv : '0;
      ok_q    <= res.crc_ok;
      retry_q <= res.retry;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, temp_q};
  assign m_axis_tuser  = {retry_q, ok_q};

endmodule
